// ----- src/cau_pkg.sv -----
`default_nettype none
package cau_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;

   // quotient bits kept by the divider: 31 integer bits and the fraction
   localparam int DIV_STEPS  = 31 + FRAC_BITS;
   localparam int SQRT_STEPS = 32;
   localparam int MAX_DS     = (DIV_STEPS > SQRT_STEPS) ? DIV_STEPS : SQRT_STEPS;
   localparam int NUM_CELLS  = (MAX_DS > CORDIC_STEPS) ? MAX_DS : CORDIC_STEPS;
   localparam int CELL_IDX_W = $clog2(NUM_CELLS);

   localparam int CORD_W = 36;
   localparam int ANG_W  = 35;

   localparam logic [3:0] OP_ADD   = 4'd0;
   localparam logic [3:0] OP_SUB   = 4'd1;
   localparam logic [3:0] OP_MUL   = 4'd2;
   localparam logic [3:0] OP_DIV   = 4'd3;
   localparam logic [3:0] OP_CONJ  = 4'd4;
   localparam logic [3:0] OP_MOD   = 4'd5;
   localparam logic [3:0] OP_MODSQ = 4'd6;
   localparam logic [3:0] OP_ARG   = 4'd7;
   localparam logic [3:0] OP_EQ    = 4'd8;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIVZ = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic [3:0]           opcode;
      logic [31:0]          res_real;
      logic [31:0]          res_imag;
      logic                 is_equal;
      logic [1:0]           status;
      logic                 div_zero;
      logic                 neg_r;
      logic                 neg_i;
      logic                 ovf_r;
      logic                 ovf_i;
      logic [63:0]          div_d;
      logic [63:0]          num_r;
      logic [63:0]          num_i;
      logic [63:0]          rem_r;
      logic [63:0]          rem_i;
      logic [DIV_STEPS-1:0] quo_r;
      logic [DIV_STEPS-1:0] quo_i;
      logic [63:0]          sq_val;
      logic [33:0]          sq_rem;
      logic [31:0]          sq_root;
      logic                 cord_zero;
      logic [CORD_W-1:0]    cord_x;
      logic [CORD_W-1:0]    cord_y;
      logic [ANG_W-1:0]     cord_z;
   } cell_data_type;

   // atan(2^-i) in Q30
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'd843314857;
         5'd1:  v = 32'd497837829;
         5'd2:  v = 32'd263043837;
         5'd3:  v = 32'd133525159;
         5'd4:  v = 32'd67021687;
         5'd5:  v = 32'd33543516;
         5'd6:  v = 32'd16775851;
         5'd7:  v = 32'd8388437;
         5'd8:  v = 32'd4194283;
         5'd9:  v = 32'd2097149;
         5'd10: v = 32'd1048576;
         5'd11: v = 32'd524288;
         5'd12: v = 32'd262144;
         5'd13: v = 32'd131072;
         5'd14: v = 32'd65536;
         5'd15: v = 32'd32768;
         5'd16: v = 32'd16384;
         5'd17: v = 32'd8192;
         5'd18: v = 32'd4096;
         5'd19: v = 32'd2048;
         5'd20: v = 32'd1024;
         5'd21: v = 32'd512;
         5'd22: v = 32'd256;
         5'd23: v = 32'd128;
         5'd24: v = 32'd64;
         5'd25: v = 32'd32;
         5'd26: v = 32'd16;
         5'd27: v = 32'd8;
         5'd28: v = 32'd4;
         5'd29: v = 32'd2;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ----- src/cau_front.sv -----
`default_nettype none
module cau_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [3:0]            req_opcode,
   input  wire logic signed [31:0]    req_a_real,
   input  wire logic signed [31:0]    req_a_imag,
   input  wire logic signed [31:0]    req_b_real,
   input  wire logic signed [31:0]    req_b_imag,
   output logic                       out_valid,
   input  wire logic                  out_stall,
   output cau_pkg::cell_data_type     out_data
);

   // multiply stage
   logic               mul_valid_ff, mul_valid_in, mul_stall;
   logic [3:0]         op_ff;
   logic signed [31:0] ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [63:0] p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;
   logic               square_sel;

   // setup stage
   logic                   set_valid_ff, set_valid_in, set_stall;
   cau_pkg::cell_data_type set_data_ff, set_data_in;

   logic signed [64:0] e0, e1, e2, e3;
   logic signed [64:0] sum_a, dif_a, sum_b, dif_b, mag_r, mag_i;
   logic signed [32:0] add_r, add_i, sub_r, sub_i;
   logic [32:0]        rr_s, ri_s;
   logic [63:0]        sq_shift;
   logic [31:0]        atan0;

   function automatic logic [32:0] sat_word(input logic signed [64:0] v);
      if (v > 65'sd2147483647) begin
         return {1'b1, 32'h7FFF_FFFF};
      end else if (v < -65'sd2147483648) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, v[31:0]};
   endfunction

   assign set_stall = set_valid_ff && out_stall;
   assign mul_stall = mul_valid_ff && set_stall;
   assign req_stall = mul_stall;

   assign square_sel = (req_opcode == cau_pkg::OP_MOD) || (req_opcode == cau_pkg::OP_MODSQ);
   assign p0_in = req_a_real * (square_sel ? req_a_real : req_b_real);
   assign p1_in = req_a_imag * (square_sel ? req_a_imag : req_b_imag);
   assign p2_in = req_a_real * req_b_imag;
   assign p3_in = req_a_imag * req_b_real;
   assign p4_in = req_b_real * req_b_real;
   assign p5_in = req_b_imag * req_b_imag;

   assign mul_valid_in = mul_stall ? mul_valid_ff : req_valid;
   assign set_valid_in = set_stall ? set_valid_ff : mul_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         set_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         set_valid_ff <= set_valid_in;
      end
      if (req_valid && !mul_stall) begin
         op_ff <= req_opcode;
         ar_ff <= req_a_real;
         ai_ff <= req_a_imag;
         br_ff <= req_b_real;
         bi_ff <= req_b_imag;
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         p4_ff <= p4_in;
         p5_ff <= p5_in;
      end
      if (mul_valid_ff && !set_stall) begin
         set_data_ff <= set_data_in;
      end
   end

   always_comb begin
      e0 = {p0_ff[63], p0_ff};
      e1 = {p1_ff[63], p1_ff};
      e2 = {p2_ff[63], p2_ff};
      e3 = {p3_ff[63], p3_ff};
      sum_a = e0 + e1;
      dif_a = e0 - e1;
      sum_b = e2 + e3;
      dif_b = e3 - e2;
      mag_r = sum_a[64] ? -sum_a : sum_a;
      mag_i = dif_b[64] ? -dif_b : dif_b;
      add_r = 33'(ar_ff) + 33'(br_ff);
      add_i = 33'(ai_ff) + 33'(bi_ff);
      sub_r = 33'(ar_ff) - 33'(br_ff);
      sub_i = 33'(ai_ff) - 33'(bi_ff);
      sq_shift = sum_a[63:0] >> cau_pkg::FRAC_BITS;
      atan0 = cau_pkg::atan_q30(5'd0);
      rr_s = '0;
      ri_s = '0;

      set_data_in = '0;
      set_data_in.opcode = op_ff;

      unique case (op_ff)
         cau_pkg::OP_ADD: begin
            rr_s = sat_word(65'(add_r));
            ri_s = sat_word(65'(add_i));
         end
         cau_pkg::OP_SUB: begin
            rr_s = sat_word(65'(sub_r));
            ri_s = sat_word(65'(sub_i));
         end
         cau_pkg::OP_MUL: begin
            rr_s = sat_word(dif_a >>> cau_pkg::FRAC_BITS);
            ri_s = sat_word(sum_b >>> cau_pkg::FRAC_BITS);
         end
         cau_pkg::OP_CONJ: begin
            rr_s = sat_word(65'(ar_ff));
            ri_s = sat_word(-65'(ai_ff));
         end
         cau_pkg::OP_MODSQ: begin
            if (sq_shift > 64'd2147483647) begin
               rr_s = {1'b1, 32'h7FFF_FFFF};
            end else begin
               rr_s = {1'b0, sq_shift[31:0]};
            end
         end
         cau_pkg::OP_EQ: begin
            set_data_in.is_equal = (ar_ff == br_ff) && (ai_ff == bi_ff);
         end
         default: begin
            rr_s = '0;
         end
      endcase

      set_data_in.res_real = rr_s[31:0];
      set_data_in.res_imag = ri_s[31:0];
      set_data_in.status   = (rr_s[32] || ri_s[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;

      // divider seed: remainder starts with the bits above the integer part
      set_data_in.div_d    = p4_ff[63:0] + p5_ff[63:0];
      set_data_in.div_zero = (set_data_in.div_d == 64'd0);
      set_data_in.neg_r    = sum_a[64];
      set_data_in.neg_i    = dif_b[64];
      set_data_in.num_r    = mag_r[63:0];
      set_data_in.num_i    = mag_i[63:0];
      set_data_in.rem_r    = {31'd0, mag_r[63:31]};
      set_data_in.rem_i    = {31'd0, mag_i[63:31]};

      set_data_in.sq_val = sum_a[63:0];

      // turn a left-half vector into the right half first
      set_data_in.cord_zero = (ar_ff == 32'sd0) && (ai_ff == 32'sd0);
      if (ar_ff < 0) begin
         if (ai_ff >= 0) begin
            set_data_in.cord_x = cau_pkg::CORD_W'(ai_ff);
            set_data_in.cord_y = -cau_pkg::CORD_W'(ar_ff);
            set_data_in.cord_z = cau_pkg::ANG_W'({atan0, 1'b0});
         end else begin
            set_data_in.cord_x = -cau_pkg::CORD_W'(ai_ff);
            set_data_in.cord_y = cau_pkg::CORD_W'(ar_ff);
            set_data_in.cord_z = cau_pkg::ANG_W'(0) - cau_pkg::ANG_W'({atan0, 1'b0});
         end
      end else begin
         set_data_in.cord_x = cau_pkg::CORD_W'(ar_ff);
         set_data_in.cord_y = cau_pkg::CORD_W'(ai_ff);
         set_data_in.cord_z = '0;
      end
   end

   assign out_valid = set_valid_ff;
   assign out_data  = set_data_ff;

endmodule
`default_nettype wire

// ----- src/cau_cell.sv -----
`default_nettype none
module cau_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [cau_pkg::CELL_IDX_W-1:0]  cell_idx,
   input  wire logic                            in_valid,
   output logic                                 in_stall,
   input  wire cau_pkg::cell_data_type          in_data,
   output logic                                 out_valid,
   input  wire logic                            out_stall,
   output cau_pkg::cell_data_type               out_data
);

   logic                   valid_ff, valid_in;
   cau_pkg::cell_data_type data_ff, data_in;

   logic [64:0]                      step_r, step_i;
   logic [35:0]                      sq_trial, sq_sub;
   logic signed [cau_pkg::CORD_W-1:0] cx, cy, dx, dy;
   logic [cau_pkg::ANG_W-1:0]        ang;

   // one restoring divide step: bring in a numerator bit, subtract if it fits
   function automatic logic [64:0] div_step(input logic [63:0] rem, input logic nb,
                                            input logic [63:0] d);
      logic [64:0] r2;
      logic [64:0] diff;
      r2   = {rem, nb};
      diff = r2 - {1'b0, d};
      if (r2 >= {1'b0, d}) begin
         return {1'b1, diff[63:0]};
      end
      return {1'b0, r2[63:0]};
   endfunction

   assign in_stall = valid_ff && out_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_comb begin
      data_in  = in_data;
      step_r   = '0;
      step_i   = '0;
      sq_trial = {in_data.sq_rem, in_data.sq_val[63:62]};
      sq_sub   = {2'b00, in_data.sq_root, 2'b01};
      cx       = in_data.cord_x;
      cy       = in_data.cord_y;
      dx       = cy >>> cell_idx;
      dy       = cx >>> cell_idx;
      ang      = cau_pkg::ANG_W'(cau_pkg::atan_q30(5'(cell_idx)));

      if (int'(cell_idx) == 0) begin
         data_in.ovf_r = (in_data.rem_r >= in_data.div_d);
         data_in.ovf_i = (in_data.rem_i >= in_data.div_d);
      end

      if (int'(cell_idx) < cau_pkg::DIV_STEPS) begin
         step_r = div_step(in_data.rem_r, in_data.num_r[30], in_data.div_d);
         step_i = div_step(in_data.rem_i, in_data.num_i[30], in_data.div_d);
         data_in.rem_r = step_r[63:0];
         data_in.rem_i = step_i[63:0];
         data_in.quo_r = {in_data.quo_r[cau_pkg::DIV_STEPS-2:0], step_r[64]};
         data_in.quo_i = {in_data.quo_i[cau_pkg::DIV_STEPS-2:0], step_i[64]};
         data_in.num_r = in_data.num_r << 1;
         data_in.num_i = in_data.num_i << 1;
      end

      if (int'(cell_idx) < cau_pkg::SQRT_STEPS) begin
         if (sq_trial >= sq_sub) begin
            data_in.sq_rem  = 34'(sq_trial - sq_sub);
            data_in.sq_root = {in_data.sq_root[30:0], 1'b1};
         end else begin
            data_in.sq_rem  = sq_trial[33:0];
            data_in.sq_root = {in_data.sq_root[30:0], 1'b0};
         end
         data_in.sq_val = in_data.sq_val << 2;
      end

      if (int'(cell_idx) < cau_pkg::CORDIC_STEPS) begin
         if (!cy[cau_pkg::CORD_W-1]) begin
            data_in.cord_x = cx + dx;
            data_in.cord_y = cy - dy;
            data_in.cord_z = in_data.cord_z + ang;
         end else begin
            data_in.cord_x = cx - dx;
            data_in.cord_y = cy + dy;
            data_in.cord_z = in_data.cord_z - ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && !in_stall) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ----- src/cau_finish.sv -----
`default_nettype none
module cau_finish (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_stall,
   input  wire cau_pkg::cell_data_type  in_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [31:0]                  rsp_res_real,
   output logic [31:0]                  rsp_res_imag,
   output logic                         rsp_is_equal,
   output logic [1:0]                   rsp_status
);

   localparam logic [cau_pkg::ANG_W-1:0] ROUND_HALF =
      cau_pkg::ANG_W'(1) << (29 - cau_pkg::FRAC_BITS);

   logic        valid_ff, valid_in;
   logic [31:0] real_ff, imag_ff, real_in, imag_in;
   logic        eq_ff, eq_in;
   logic [1:0]  status_ff, status_in;

   logic [32:0]                      part_r, part_i;
   logic [cau_pkg::ANG_W-1:0]        ang_round;
   logic signed [cau_pkg::ANG_W-1:0] ang_shift;

   // clamp a quotient magnitude to the signed range, then apply the sign
   function automatic logic [32:0] div_result(input logic neg, input logic ovf,
                                              input logic [cau_pkg::DIV_STEPS-1:0] q);
      logic [cau_pkg::DIV_STEPS-1:0] lim;
      logic [cau_pkg::DIV_STEPS-1:0] qs;
      logic                          sat;
      lim = neg ? cau_pkg::DIV_STEPS'(64'h8000_0000) : cau_pkg::DIV_STEPS'(64'h7FFF_FFFF);
      sat = ovf || (q > lim);
      qs  = sat ? lim : q;
      return {sat, neg ? -qs[31:0] : qs[31:0]};
   endfunction

   assign in_stall = valid_ff && rsp_stall;
   assign valid_in = in_stall ? valid_ff : in_valid;

   always_comb begin
      real_in   = in_data.res_real;
      imag_in   = in_data.res_imag;
      eq_in     = in_data.is_equal;
      status_in = in_data.status;
      part_r    = div_result(in_data.neg_r, in_data.ovf_r, in_data.quo_r);
      part_i    = div_result(in_data.neg_i, in_data.ovf_i, in_data.quo_i);
      ang_round = in_data.cord_z + ROUND_HALF;
      ang_shift = $signed(ang_round) >>> (30 - cau_pkg::FRAC_BITS);

      unique case (in_data.opcode)
         cau_pkg::OP_DIV: begin
            if (in_data.div_zero) begin
               real_in   = '0;
               imag_in   = '0;
               status_in = cau_pkg::ST_DIVZ;
            end else begin
               real_in   = part_r[31:0];
               imag_in   = part_i[31:0];
               status_in = (part_r[32] || part_i[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
         end
         cau_pkg::OP_MOD: begin
            imag_in = '0;
            if (in_data.sq_root[31]) begin
               real_in   = 32'h7FFF_FFFF;
               status_in = cau_pkg::ST_SAT;
            end else begin
               real_in   = in_data.sq_root;
               status_in = cau_pkg::ST_OK;
            end
         end
         cau_pkg::OP_ARG: begin
            imag_in   = '0;
            status_in = cau_pkg::ST_OK;
            real_in   = in_data.cord_zero ? 32'd0 : ang_shift[31:0];
         end
         default: begin
            real_in = in_data.res_real;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && !in_stall) begin
         real_ff   <= real_in;
         imag_ff   <= imag_in;
         eq_ff     <= eq_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_res_real = real_ff;
   assign rsp_res_imag = imag_ff;
   assign rsp_is_equal = eq_ff;
   assign rsp_status   = status_ff;

endmodule
`default_nettype wire

// ----- src/complex_arithmetic_unit_top.sv -----
// Complex arithmetic unit on signed Q16.16 operands.
// Request channel: req_valid / req_stall with req_opcode and the operands
// a (req_a_real, req_a_imag) and b (req_b_real, req_b_imag). A beat is taken
// at a rising edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall with rsp_res_real, rsp_res_imag,
// rsp_is_equal and rsp_status (0 ok, 1 divide by zero, 2 saturated).
// Every request beat gives exactly one response beat, in order.
// Path: two front stages (products, then sums and seeding), one cell per
// quotient bit of the divider, then the output register. The divider is
// the longest of the three digit recurrences sharing the cell row
// (divide, square root, CORDIC), so it sets the row length.
// Throughput: one beat per cycle while no stall holds the row; every stage holds one item in flight.
// Stall: a stalled response holds its beat; stages upstream keep filling
// empty slots, so requests are still taken until the whole row is full.
// Reset: synchronous, clears every stage valid; no clearing pass is needed.
`default_nettype none
module complex_arithmetic_unit_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_opcode,
   input  wire logic signed [31:0] req_a_real,
   input  wire logic signed [31:0] req_a_imag,
   input  wire logic signed [31:0] req_b_real,
   input  wire logic signed [31:0] req_b_imag,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_res_real,
   output logic signed [31:0]      rsp_res_imag,
   output logic                    rsp_is_equal,
   output logic [1:0]              rsp_status
);

   localparam int NC = cau_pkg::NUM_CELLS;

   // chain slot g feeds cell g; slot NC feeds the output stage
   logic                   chain_valid [NC+1];
   logic                   chain_stall [NC+1];
   cau_pkg::cell_data_type chain_data  [NC+1];

   cau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_a_real (req_a_real),
      .req_a_imag (req_a_imag),
      .req_b_real (req_b_real),
      .req_b_imag (req_b_imag),
      .out_valid  (chain_valid[0]),
      .out_stall  (chain_stall[0]),
      .out_data   (chain_data[0])
   );

   // step cells: each advances the divide a digit; root below SQRT_STEPS, angle below CORDIC_STEPS
   for (genvar g = 0; g < NC; g++) begin : g_cell
      cau_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (cau_pkg::CELL_IDX_W'(g)),
         .in_valid  (chain_valid[g]),
         .in_stall  (chain_stall[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_stall (chain_stall[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   // final clamp, sign and rounding, then the response register
   cau_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[NC]),
      .in_stall     (chain_stall[NC]),
      .in_data      (chain_data[NC]),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_res_real (rsp_res_real),
      .rsp_res_imag (rsp_res_imag),
      .rsp_is_equal (rsp_is_equal),
      .rsp_status   (rsp_status)
   );

endmodule
`default_nettype wire

// ----- src/cau_checker.sv -----
`default_nettype none
module cau_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_res_real,
   input wire logic [31:0] rsp_res_imag,
   input wire logic        rsp_is_equal,
   input wire logic [1:0]  rsp_status
);

   // the row is empty right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // an equal flag only comes from a compare, which has zero parts and ok status
   a_equal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_equal |->
         rsp_res_real == 32'd0 && rsp_res_imag == 32'd0 && rsp_status == 2'd0)
      else $error("equal flag with nonzero result");

   // divide by zero reports zero parts
   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == 2'd1 |->
         rsp_res_real == 32'd0 && rsp_res_imag == 32'd0 && !rsp_is_equal)
      else $error("divide by zero with nonzero result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_res_real) && $stable(rsp_res_imag) &&
         $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (.*);
`default_nettype wire

// ----- tb/complex_arithmetic_unit_top_tb.sv -----
`default_nettype none
module complex_arithmetic_unit_top_tb;

   localparam int LATENCY = 3 + cau_pkg::DIV_STEPS;

   typedef struct packed {
      logic [31:0] res_real;
      logic [31:0] res_imag;
      logic        is_equal;
      logic [1:0]  status;
   } answer_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [3:0]         req_opcode = cau_pkg::OP_ADD;
   logic signed [31:0] req_a_real = '0;
   logic signed [31:0] req_a_imag = '0;
   logic signed [31:0] req_b_real = '0;
   logic signed [31:0] req_b_imag = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_res_real;
   logic signed [31:0] rsp_res_imag;
   logic               rsp_is_equal;
   logic [1:0]         rsp_status;

   answer_type pending_answers[$];
   int      error_count = 0;
   int      beats_sent = 0;
   int      beats_checked = 0;
   int      hold_off_cycles = 0;   // long receiver hold, counted below
   bit      stall_random = 1'b0;

   complex_arithmetic_unit_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_a_real(req_a_real), .req_a_imag(req_a_imag),
      .req_b_real(req_b_real), .req_b_imag(req_b_imag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_res_real(rsp_res_real), .rsp_res_imag(rsp_res_imag),
      .rsp_is_equal(rsp_is_equal), .rsp_status(rsp_status)
   );

   always #6 clock = ~clock;

   // Clamp to 32 bits, flagging saturation.
   function automatic logic [31:0] clamp32(input logic signed [127:0] v,
                                           inout logic [1:0] st);
      if (v > 128'sd2147483647) begin
         st = cau_pkg::ST_SAT;
         return 32'h7fffffff;
      end
      if (v < -128'sd2147483648) begin
         st = cau_pkg::ST_SAT;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   // Arithmetic shift right is floor division for signed values.
   function automatic logic signed [127:0] floor_div(input logic signed [127:0] v,
                                                     input int s);
      return v >>> s;
   endfunction

   // Truncated quotient of n * 2^FRAC_BITS / d, saturated.
   function automatic logic [31:0] quotient_part(input logic signed [127:0] n,
                                                 input logic signed [127:0] d,
                                                 inout logic [1:0] st);
      logic [127:0] mag, q;
      logic         neg;
      neg = n < 0;
      mag = neg ? -n : n;
      q   = (mag << cau_pkg::FRAC_BITS) / d;
      if (neg) begin
         if (q > 128'h80000000) begin
            st = cau_pkg::ST_SAT;
            q  = 128'h80000000;
         end
         return clamp32(-$signed(q), st);
      end
      if (q > 128'h7fffffff) begin
         st = cau_pkg::ST_SAT;
         q  = 128'h7fffffff;
      end
      return q[31:0];
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         logic [63:0] t;
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // Angle of (x, y) by vectoring CORDIC, Q30 accumulation.
   function automatic logic signed [63:0] angle_of(input logic signed [63:0] x0,
                                                   input logic signed [63:0] y0);
      logic signed [63:0] x, y, z, t, dx, dy;
      x = x0; y = y0; z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t;
            z = 2 * $signed({32'd0, cau_pkg::atan_q30(5'd0)});
         end else begin
            t = x; x = -y; y = t;
            z = -2 * $signed({32'd0, cau_pkg::atan_q30(5'd0)});
         end
      end
      for (int i = 0; i < cau_pkg::CORDIC_STEPS && i < 31; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += $signed({32'd0, cau_pkg::atan_q30(5'(i))});
         end else begin
            x -= dx; y += dy; z -= $signed({32'd0, cau_pkg::atan_q30(5'(i))});
         end
      end
      return (z + (64'sd1 << (29 - cau_pkg::FRAC_BITS))) >>> (30 - cau_pkg::FRAC_BITS);
   endfunction

   function automatic answer_type compute_answer(input logic [3:0] op,
                                                 input logic signed [31:0] ar_in,
                                                 input logic signed [31:0] ai_in,
                                                 input logic signed [31:0] br_in,
                                                 input logic signed [31:0] bi_in);
      answer_type          ans;
      logic signed [127:0] ar, ai, br, bi, d;
      logic [63:0]         m;
      ans = '0;
      ar = ar_in; ai = ai_in; br = br_in; bi = bi_in;
      case (op) inside
         cau_pkg::OP_ADD: begin
            ans.res_real = clamp32(ar + br, ans.status);
            ans.res_imag = clamp32(ai + bi, ans.status);
         end
         cau_pkg::OP_SUB: begin
            ans.res_real = clamp32(ar - br, ans.status);
            ans.res_imag = clamp32(ai - bi, ans.status);
         end
         cau_pkg::OP_MUL: begin
            ans.res_real = clamp32(floor_div(ar * br - ai * bi, cau_pkg::FRAC_BITS),
                                   ans.status);
            ans.res_imag = clamp32(floor_div(ar * bi + ai * br, cau_pkg::FRAC_BITS),
                                   ans.status);
         end
         cau_pkg::OP_DIV: begin
            d = br * br + bi * bi;
            if (d == 0) ans.status = cau_pkg::ST_DIVZ;
            else begin
               ans.res_real = quotient_part(ar * br + ai * bi, d, ans.status);
               ans.res_imag = quotient_part(ai * br - ar * bi, d, ans.status);
            end
         end
         cau_pkg::OP_CONJ: begin
            ans.res_real = ar_in;
            ans.res_imag = clamp32(-ai, ans.status);
         end
         cau_pkg::OP_MOD, cau_pkg::OP_MODSQ: begin
            d = ar * ar + ai * ai;   // fits 64 bits unsigned
            m = (op == cau_pkg::OP_MOD) ? root_floor(d[63:0])
                                        : d[63:0] >> cau_pkg::FRAC_BITS;
            if (m > 64'h7fffffff) begin
               m = 64'h7fffffff;
               ans.status = cau_pkg::ST_SAT;
            end
            ans.res_real = m[31:0];
         end
         cau_pkg::OP_ARG: ans.res_real = clamp32(angle_of(ar_in, ai_in), ans.status);
         cau_pkg::OP_EQ: ans.is_equal = (ar_in == br_in) && (ai_in == bi_in);
         default: ;
      endcase
      return ans;
   endfunction

   // Send one beat after a random gap (none with no_gap); hold until accepted. Valid stays up
   // after the beat so the next call can follow back to back.
   task automatic send_beat(input logic [3:0] op, input logic [31:0] ar,
                            input logic [31:0] ai, input logic [31:0] br,
                            input logic [31:0] bi, input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_a_real <= ar;
      req_a_imag <= ai;
      req_b_real <= br;
      req_b_imag <= bi;
      pending_answers.push_back(compute_answer(op, ar, ai, br, bi));
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // Receiver: a long hold, or random stalls drawn anew after each accepted beat.
   initial begin
      int wait_left;
      wait_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_stall <= 1'b1;
         end else if (stall_random) begin
            if (wait_left == 0 && rsp_valid && !rsp_stall)
               wait_left = $urandom_range(0, 11);
            if (wait_left > 0) begin
               wait_left--;
               rsp_stall <= 1'b1;
            end else rsp_stall <= 1'b0;
         end else rsp_stall <= 1'b0;
      end
   end

   // Check each accepted response beat against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         answer_type want;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response beat real=%h imag=%h", $realtime,
                     rsp_res_real, rsp_res_imag);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            beats_checked++;
            if (rsp_res_real !== want.res_real) begin
               $display("%0t: res_real expected %h actual %h", $realtime,
                        want.res_real, rsp_res_real);
               error_count++;
            end
            if (rsp_res_imag !== want.res_imag) begin
               $display("%0t: res_imag expected %h actual %h", $realtime,
                        want.res_imag, rsp_res_imag);
               error_count++;
            end
            if (rsp_is_equal !== want.is_equal) begin
               $display("%0t: is_equal expected %b actual %b", $realtime,
                        want.is_equal, rsp_is_equal);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return 32'd0;
         3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
         4: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed_edges();
      logic [31:0] mx, mn;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      send_beat(cau_pkg::OP_ADD, mx, mn, 32'd1, 32'hffffffff);
      send_beat(cau_pkg::OP_SUB, mn, mx, 32'd1, 32'hffffffff);
      send_beat(cau_pkg::OP_MUL, mx, mx, mn, mx);
      send_beat(cau_pkg::OP_MUL, mn, mn, mn, mn);
      send_beat(cau_pkg::OP_MUL, 32'h00020000, 32'h00010000, 32'h00030000, 32'hffff0000);
      send_beat(cau_pkg::OP_DIV, 32'h00010000, 32'h00010000, 32'd0, 32'd0);
      send_beat(cau_pkg::OP_DIV, mx, mn, 32'd1, 32'd0);
      send_beat(cau_pkg::OP_DIV, mn, 32'd0, 32'd0, 32'd1);
      send_beat(cau_pkg::OP_DIV, 32'h00060000, 32'hfffe0000, 32'h00020000, 32'h00010000);
      send_beat(cau_pkg::OP_CONJ, mn, mn, 32'd0, 32'd0);
      send_beat(cau_pkg::OP_CONJ, mx, mx, 32'd0, 32'd0);
      send_beat(cau_pkg::OP_MOD, mn, mn, 32'd0, 32'd0);
      send_beat(cau_pkg::OP_MOD, 32'h00030000, 32'h00040000, 32'd0, 32'd0);
      send_beat(cau_pkg::OP_MODSQ, mx, mn, 32'd0, 32'd0);
      send_beat(cau_pkg::OP_MODSQ, 32'h00010000, 32'h00010000, 32'd0, 32'd0);
      send_beat(cau_pkg::OP_ARG, 32'd0, 32'd0, 32'd0, 32'd0);
      send_beat(cau_pkg::OP_ARG, 32'hffff0000, 32'd0, 32'd0, 32'd0);
      send_beat(cau_pkg::OP_ARG, mn, 32'hffffffff, 32'd0, 32'd0);
      send_beat(cau_pkg::OP_ARG, 32'd0, mn, 32'd0, 32'd0);
      send_beat(cau_pkg::OP_EQ, mx, mn, mx, mn);
      send_beat(cau_pkg::OP_EQ, mx, mn, mx, mx);
      send_beat(4'd9, mx, mx, mx, mx);
      send_beat(4'd15, mn, mn, mn, mn);
   endtask

   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++) begin
         logic [3:0] op;
         op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
         send_beat(op, pick_value(), pick_value(), pick_value(), pick_value());
      end
   endtask

   // Hold the receiver for a long stretch while requests keep coming.
   task automatic test_backpressure();
      hold_off_cycles = 3 * LATENCY;
      for (int n = 0; n < 2 * LATENCY; n++)
         send_beat(cau_pkg::OP_DIV, $urandom, $urandom, $urandom, $urandom, 1);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_backpressure();
      stall_random = 1'b1;
      test_random_traffic(1300);
      drain_results();
      $display("Covered %0d request beats, %0d checked: edge values, every opcode,",
               beats_sent, beats_checked);
      $display("divide by zero, saturation, random gaps and a full-pipe hold.");
      if (error_count == 0 && pending_answers.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
